// File: rtl/quadratic_probe_hash_set_core_defines.svh
// assertion macros shared by the hash set rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef QUADRATIC_PROBE_HASH_SET_CORE_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_SET_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define QPHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define QPHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/qphs_pkg.sv
// shared types, codes and constants for the quadratic probe hash set
// no dependencies
`default_nettype none

package qphs_pkg;

    // field widths
    localparam int unsigned KEY_W    = 31;
    localparam int unsigned SIZE_W   = 11;
    localparam int unsigned COUNT_W  = 10;

    // table size limits and reset value
    localparam int unsigned     SIZE_MIN      = 2;
    localparam int unsigned     SIZE_MAX      = 1024;
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 11'd5;
    localparam int unsigned     DEFAULT_DEPTH = 1024;

    // apb port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // register index (byte address divided by four)
    typedef logic [APB_AW-3:0] reg_idx_t;
    localparam reg_idx_t REG_TABLE_SIZE = 1'b0;

    // remainder unit: key padded to an even width, two bits per step
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIV_STEPS = DIV_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TEST   = 1'b1;

    typedef enum logic [2:0] {
        RES_STORED    = 3'd0,
        RES_DUPLICATE = 3'd1,
        RES_FULL      = 3'd2,
        RES_FOUND     = 3'd3,
        RES_ABSENT    = 3'd4
    } status_t;

    typedef struct packed {
        logic              opcode;
        logic [KEY_W-1:0]  key;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [COUNT_W-1:0] item_count;
    } out_item_t;

    // one table slot
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_INIT,
        S_READ,
        S_CHECK,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic div_step;
        logic probe_init;
        logic advance;
        logic finish;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic slot_empty;
        logic key_match;
        logic probe_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/qphs_ctrl.sv
// sequencer for the hash set: clearing pass, remainder, probe walk, result
// depends on qphs_pkg
`default_nettype none

module qphs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  qphs_pkg::stat_t stat,
    output qphs_pkg::cmd_t  cmd
);

    import qphs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.slot_empty || stat.key_match || stat.probe_last)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_INIT:
            begin
                cmd.probe_init = 1'b1;
            end
            S_READ:
            begin
                cmd = '0;
            end
            S_CHECK:
            begin
                if (stat.slot_empty || stat.key_match || stat.probe_last)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_RESULT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/qphs_dp.sv
// datapath: remainder unit, probe index arithmetic, slot memory, count, output register
// depends on qphs_pkg and quadratic_probe_hash_set_core_defines.svh
`default_nettype none

`include "quadratic_probe_hash_set_core_defines.svh"

module qphs_dp #(
    parameter int unsigned TABLE_DEPTH = qphs_pkg::DEFAULT_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qphs_pkg::cmd_t                    cmd,
    output qphs_pkg::stat_t                   stat,
    input  qphs_pkg::in_item_t                in_item,
    input  logic [qphs_pkg::SIZE_W-1:0]       table_size,
    output logic [qphs_pkg::COUNT_W-1:0]      item_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output qphs_pkg::out_item_t               out_item
);

    import qphs_pkg::*;

    localparam int unsigned IDX_W    = $clog2(TABLE_DEPTH);
    localparam int unsigned SIZE_CAP = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;

    // fold a sum below twice the modulus back below it
    function automatic logic [SIZE_W-1:0] mod_fold(
        input logic [SIZE_W:0]   v,
        input logic [SIZE_W-1:0] m
    );
        logic [SIZE_W:0] diff;
        diff = v - {1'b0, m};
        if (v >= {1'b0, m})
        begin
            return diff[SIZE_W-1:0];
        end
        return v[SIZE_W-1:0];
    endfunction

    // effective number of slots
    logic [SIZE_W-1:0] m_eff;
    logic [SIZE_W:0]   m_wide;

    always_comb
    begin
        if (table_size < SIZE_W'(SIZE_MIN))
        begin
            m_eff = SIZE_W'(SIZE_MIN);
        end
        else if (table_size > SIZE_W'(SIZE_CAP))
        begin
            m_eff = SIZE_W'(SIZE_CAP);
        end
        else
        begin
            m_eff = table_size;
        end
        m_wide = {1'b0, m_eff};
    end

    // item registers
    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_item.opcode;
            key_reg <= in_item.key;
        end
    end

    // remainder unit, two dividend bits per cycle
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dvd_next;
    logic [SIZE_W-1:0]    rem_reg;
    logic [SIZE_W-1:0]    rem_next;
    logic [SIZE_W-1:0]    rem_half;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    always_comb
    begin
        rem_half     = mod_fold({rem_reg, dvd_reg[DIV_W-1]}, m_eff);
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.accept)
        begin
            dvd_next     = DIV_W'(in_item.key);
            rem_next     = '0;
            div_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next     = {dvd_reg[DIV_W-3:0], 2'b00};
            rem_next     = mod_fold({rem_half, dvd_reg[DIV_W-2]}, m_eff);
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
    end

    // probe index, squared step and odd increment, all kept below m
    logic [SIZE_W-1:0] idx_reg;
    logic [SIZE_W-1:0] idx_next;
    logic [SIZE_W-1:0] sq_reg;
    logic [SIZE_W-1:0] sq_next;
    logic [SIZE_W-1:0] odd_reg;
    logic [SIZE_W-1:0] odd_next;
    logic [SIZE_W-1:0] step_reg;
    logic [SIZE_W-1:0] step_next;

    always_comb
    begin
        idx_next  = idx_reg;
        sq_next   = sq_reg;
        odd_next  = odd_reg;
        step_next = step_reg;
        if (cmd.probe_init)
        begin
            idx_next  = rem_reg;
            sq_next   = SIZE_W'(1);
            odd_next  = mod_fold((SIZE_W+1)'(3), m_eff);
            step_next = '0;
        end
        else if (cmd.advance)
        begin
            idx_next  = mod_fold({1'b0, idx_reg} + {1'b0, sq_reg}, m_eff);
            sq_next   = mod_fold({1'b0, sq_reg} + {1'b0, odd_reg}, m_eff);
            odd_next  = mod_fold({1'b0, odd_reg} + (SIZE_W+1)'(2), m_eff);
            step_next = step_reg + SIZE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sq_reg   <= sq_next;
        odd_reg  <= odd_next;
        step_reg <= step_next;
    end

    // clearing pass counter and stored key count
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [IDX_W-1:0]   clr_cnt_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   count_plus;
    logic [COUNT_W:0]   count_dbl;
    logic               full;
    logic               store_now;

    // slot memory
    slot_t            mem [TABLE_DEPTH];
    slot_t            rd_reg;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic [IDX_W-1:0] rd_addr;

    assign rd_addr = IDX_W'(idx_reg);

    always_comb
    begin
        wr_en   = cmd.clr_step || store_now;
        wr_addr = cmd.clr_step ? clr_cnt_reg : rd_addr;
        wr_data = '0;
        if (!cmd.clr_step)
        begin
            wr_data.valid = 1'b1;
            wr_data.key   = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // probe outcome and result code
    status_t res_status;
    status_t res_status_reg;

    always_comb
    begin
        stat.clr_last   = (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1));
        stat.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        stat.slot_empty = !rd_reg.valid;
        stat.key_match  = rd_reg.valid && (rd_reg.key == key_reg);
        stat.probe_last = (step_reg == (m_eff - SIZE_W'(1)));
        stat.out_free   = !out_valid || !out_stall;

        count_plus = {1'b0, count_reg} + (COUNT_W+1)'(1);
        count_dbl  = {count_reg, 1'b0};
        full       = ({count_plus, 1'b0} >= {1'b0, m_wide});

        store_now  = 1'b0;
        if (op_reg == OP_INSERT)
        begin
            if (stat.key_match)
            begin
                res_status = RES_DUPLICATE;
            end
            else if (!stat.slot_empty || full)
            begin
                res_status = RES_FULL;
            end
            else
            begin
                res_status = RES_STORED;
                store_now  = cmd.finish;
            end
        end
        else
        begin
            res_status = stat.key_match ? RES_FOUND : RES_ABSENT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status_reg <= res_status;
        end
    end

    // control counters
    always_comb
    begin
        clr_cnt_next = cmd.clr_step ? (clr_cnt_reg + IDX_W'(1)) : clr_cnt_reg;
        count_next   = store_now ? count_plus[COUNT_W-1:0] : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            count_reg   <= count_next;
        end
    end

    assign item_count = count_reg;

    // output register, freed by a transfer
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;

    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.status     <= res_status_reg;
            out_item_reg.item_count <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // checks
    `QPHS_ASSERT_NOW(a_count_below_half, 1'b1, count_dbl < m_wide, "load reached one half")
    `QPHS_ASSERT_NEXT(a_rem_range, cmd.div_step, rem_reg < m_eff, "remainder out of range")
    `QPHS_ASSERT_NEXT(a_probe_range, cmd.advance, (idx_reg < m_eff) && (sq_reg < m_eff) && (odd_reg < m_eff), "probe term out of range")
    `QPHS_ASSERT_NEXT(a_count_hold, !store_now, $stable(count_reg), "count moved without a store")

endmodule

`default_nettype wire

// File: rtl/quadratic_probe_hash_set_core.sv
// Open-addressing set of 31-bit keys with quadratic probing.
// Input channel (in_valid / in_stall / in_item) carries an opcode and a key:
// insert or membership test. Each item gives exactly one result on the
// output channel (out_valid / out_stall / out_item): a status code and the
// number of keys held after the operation.
// The home slot is found by a remainder unit that retires two key bits per
// cycle; each probe then has a registered memory read (S_READ) and a
// compare and index step (S_CHECK). After the input transfer an item runs
// through S_DIV, S_INIT, then S_READ and S_CHECK for each of p probes (1 up
// to the table size) and S_RESULT, which loads the output register; a new
// item is taken only when the block is back in S_IDLE.
// A finished result sits in the output register; the next item is taken
// while it waits, and only the following result waits for the receiver.
// After reset the slot memory is cleared one entry per cycle, all TABLE_DEPTH
// entries, with in_stall high; APB writes are taken throughout.
// table_size (APB address 0) may be written only while the table is empty.
// depends on qphs_pkg, qphs_ctrl and qphs_dp
`default_nettype none

module quadratic_probe_hash_set_core #(
    parameter int unsigned TABLE_DEPTH = qphs_pkg::DEFAULT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  qphs_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output qphs_pkg::out_item_t            out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qphs_pkg::APB_AW-1:0]    paddr,
    input  logic [qphs_pkg::APB_DW-1:0]    pwdata,
    output logic [qphs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import qphs_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [COUNT_W-1:0] item_count;

    // configuration register
    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W-1:0] table_size_next;
    reg_idx_t          reg_idx;
    logic              wr_xfer;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_xfer = psel && penable && pwrite && pready;

    always_comb
    begin
        table_size_next = table_size_reg;
        prdata          = '0;
        unique case (reg_idx)
            REG_TABLE_SIZE:
            begin
                prdata = APB_DW'(table_size_reg);
                if (wr_xfer && (item_count == '0))
                begin
                    table_size_next = pwdata[SIZE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else
        begin
            table_size_reg <= table_size_next;
        end
    end

    // sequencer
    qphs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    qphs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_item    (in_item),
        .table_size (table_size_reg),
        .item_count (item_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

// File: verif/qphs_checker.sv
`timescale 1ns / 100ps
// scoreboard for the quadratic probe hash set: keeps its own copy of the key table,
// predicts the status and key count of every input transfer and checks the output channel
// depends on qphs_pkg
module qphs_checker #(
    parameter int unsigned TABLE_DEPTH = qphs_pkg::DEFAULT_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  qphs_pkg::in_item_t          in_item,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  qphs_pkg::out_item_t         out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [qphs_pkg::APB_AW-1:0] paddr,
    input  logic [qphs_pkg::APB_DW-1:0] pwdata,
    output int                          errors,
    output int                          outstanding
);
    import qphs_pkg::*;

    // mirrored block state
    logic [SIZE_W-1:0]  size_reg;
    logic               slot_used [TABLE_DEPTH];
    logic [KEY_W-1:0]   slot_key  [TABLE_DEPTH];
    logic [COUNT_W-1:0] held;

    // results still owed by the block, oldest first
    out_item_t pending_results [$];

    // slots the probe walk works on after clamping the register
    function automatic int unsigned slots_active();
        int unsigned m;
        int unsigned cap;
        m = size_reg;
        cap = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;
        if (m < SIZE_MIN)
            m = SIZE_MIN;
        if (m > cap)
            m = cap;
        return m;
    endfunction

    // walk the probe chain, update the table and return the expected result
    function automatic out_item_t set_op_result(input in_item_t it);
        int unsigned m;
        int unsigned idx;
        int unsigned probe;
        bit          hit;
        bit          empty_found;
        out_item_t   res;
        m = slots_active();
        idx = it.key % m;
        hit = 1'b0;
        empty_found = 1'b0;
        // at most one probe per active slot
        for (probe = 0; probe < m && !hit && !empty_found; probe++)
        begin
            if (!slot_used[idx])
                empty_found = 1'b1;
            else if (slot_key[idx] == it.key)
                hit = 1'b1;
            else
                idx = (idx + (probe + 1) * (probe + 1)) % m;
        end
        if (it.opcode == OP_INSERT)
        begin
            if (hit)
                res.status = RES_DUPLICATE;
            else if (!empty_found || 2 * (int'(held) + 1) >= m)
                res.status = RES_FULL;
            else
            begin
                slot_key[idx] = it.key;
                slot_used[idx] = 1'b1;
                held = held + 1'b1;
                res.status = RES_STORED;
            end
        end
        else
            res.status = hit ? RES_FOUND : RES_ABSENT;
        res.item_count = held;
        return res;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            size_reg = SIZE_RESET;
            held = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                slot_used[i] = 1'b0;
            pending_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            // output transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t qphs_checker: unexpected result, status %0d count %0d",
                             $time, out_item.status, out_item.item_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_item.status !== want.status)
                    begin
                        errors++;
                        $display("%0t qphs_checker: status expected %0d got %0d",
                                 $time, want.status, out_item.status);
                    end
                    if (out_item.item_count !== want.item_count)
                    begin
                        errors++;
                        $display("%0t qphs_checker: item_count expected %0d got %0d",
                                 $time, want.item_count, out_item.item_count);
                    end
                end
            end

            // size register only takes a write while the table is empty
            if (psel && penable && pwrite && pready
                && paddr[APB_AW-1:2] == REG_TABLE_SIZE && held == '0)
                size_reg = pwdata[SIZE_W-1:0];

            // input transfer, appended behind the older predictions
            if (in_valid && !in_stall)
                pending_results = {pending_results, set_op_result(in_item)};

            outstanding = pending_results.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// top of the hash set testbench: clock, reset, register writes, stimulus and verdict
// depends on qphs_pkg, quadratic_probe_hash_set_core and qphs_checker
module tb;
    import qphs_pkg::*;

    // 5 * 7 * 11: not prime, a probe chain reaches only 105 of the slots
    localparam int unsigned MAIN_SIZE    = 385;
    localparam int unsigned CLUSTER_SPAN = 32'h7FFF_FFFF / MAIN_SIZE - 1;
    localparam int unsigned RANDOM_ITEMS = 1125;
    localparam int unsigned POOL_KEYS    = 48;
    localparam int unsigned QUIET_LIMIT  = 20000;
    localparam logic [KEY_W-1:0] KEY_TOP = '1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    in_item_t            in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_item;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [APB_DW-1:0]   pwdata    = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  errors;
    int                  outstanding;
    bit                  steady    = 1'b0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    quadratic_probe_hash_set_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    qphs_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // receiver stalls at random outside the steady stretch
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(0, 99) < 35);

    // one input transfer, with a random gap in front of it
    task automatic send_item(input logic op, input logic [KEY_W-1:0] key);
        in_item_t it;
        bit       gap;
        it.opcode = op;
        it.key = key;
        gap = !steady && ($urandom_range(0, 99) < 35);
        if (gap)
            in_valid <= 1'b0;
        while (gap)
        begin
            @(negedge clk);
            gap = $urandom_range(0, 99) < 35;
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_TABLE_SIZE, 2'b00};
        pwdata <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending and wait for every owed result
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // watchdog on cycles without any transfer
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [KEY_W-1:0] pool [POOL_KEYS];
        logic [KEY_W-1:0] key;
        logic             op;
        int unsigned      home;
        int unsigned      mode;
        int unsigned      burst;
        int unsigned      n;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size: lookups only so the table stays empty
        send_item(OP_TEST, '0);
        send_item(OP_TEST, KEY_TOP);
        drain();

        // sizes below the range act as two slots; at two slots every insert is refused
        write_table_size(11'd0);
        send_item(OP_INSERT, '0);
        send_item(OP_TEST, '0);
        drain();
        write_table_size(11'd1);
        send_item(OP_INSERT, KEY_TOP);
        drain();
        write_table_size(11'd2);
        send_item(OP_INSERT, 31'd12345);
        send_item(OP_TEST, KEY_TOP);
        drain();

        // above the range clamps to the full depth, then the top size itself
        write_table_size(11'h7FF);
        send_item(OP_TEST, 31'd1023);
        send_item(OP_TEST, KEY_TOP);
        drain();
        write_table_size(11'd1024);
        send_item(OP_TEST, 31'd1024);
        drain();

        // working size: store, duplicate, hit, miss, collision on the home slot
        write_table_size(11'(MAIN_SIZE));
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, '0);
        send_item(OP_TEST, '0);
        send_item(OP_TEST, 31'(MAIN_SIZE));
        send_item(OP_INSERT, 31'(MAIN_SIZE));
        send_item(OP_TEST, 31'(MAIN_SIZE));
        send_item(OP_INSERT, KEY_TOP);
        send_item(OP_TEST, KEY_TOP);
        drain();

        // keys are held, so this size write must be dropped
        write_table_size(11'd2);
        send_item(OP_INSERT, 31'(2 * MAIN_SIZE));
        send_item(OP_TEST, 31'(2 * MAIN_SIZE));

        // random bursts: one crowded home slot, a reused key pool, raw noise
        for (int i = 0; i < POOL_KEYS; i++)
            pool[i] = KEY_W'($urandom());
        home = $urandom_range(0, MAIN_SIZE - 1);
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 99);
            burst = $urandom_range(4, 24);
            while (burst != 0 && n < RANDOM_ITEMS)
            begin
                steady = (n >= 450 && n < 600);
                if (mode < 40)
                begin
                    // same home slot fills the chain until the walk runs out
                    key = KEY_W'(home + MAIN_SIZE * $urandom_range(0, CLUSTER_SPAN));
                    op = ($urandom_range(0, 99) < 65) ? OP_INSERT : OP_TEST;
                end
                else if (mode < 94)
                begin
                    key = pool[$urandom_range(0, POOL_KEYS - 1)];
                    op = $urandom_range(0, 1) ? OP_TEST : OP_INSERT;
                end
                else
                begin
                    key = KEY_W'($urandom());
                    op = $urandom_range(0, 1) ? OP_TEST : OP_INSERT;
                end
                send_item(op, key);
                burst--;
                n++;
            end
        end
        steady = 1'b0;

        // wait out the last results and any stray transfer
        drain();
        repeat (100) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
